// ===== src/damped_spring_force_2d_macros.svh =====
// ----------------------------------------------------------------------------
// damped_spring_force_2d_macros
// Assertion macros shared by the checker of the spring force block.
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_2D_MACROS_SVH
`define DAMPED_SPRING_FORCE_2D_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// Constants, widths and sideband types of the damped spring force pipeline.
// ----------------------------------------------------------------------------
package dsf_pkg;

  // Fraction bits of every fixed-point value
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int FIELD_W = 32;
  localparam int DIFF_W  = FIELD_W + 1;       // exact endpoint difference
  localparam int RAD_W   = 2 * DIFF_W;        // squared length
  localparam int LEN_W   = DIFF_W;            // floor square root
  localparam int REM_W   = LEN_W + 1;         // square root remainder
  localparam int SQ_STAGES = LEN_W;           // one root bit per stage

  // Direction: magnitude of each unit component is at most 1.0
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int NUM_W   = DIFF_W + FRAC_BITS;
  localparam int DIV_STAGES = Q_W;

  // Downstream widths
  localparam int P_W     = Q_W + 1 + DIFF_W;  // signed unit * velocity
  localparam int DR_W    = P_W + 1;           // signed dot product, raw
  localparam int DOT_W   = DIFF_W + 1;        // dot magnitude after shift
  localparam int STR_W   = LEN_W;             // stretch magnitude
  localparam int KS_W    = FIELD_W + STR_W - FRAC_BITS;
  localparam int DS_W    = FIELD_W + DOT_W - FRAC_BITS;
  localparam int SM_W    = DS_W + 1;          // scalar magnitude
  localparam int S_W     = SM_W + 1;          // signed scalar
  localparam int MX_W    = Q_W + SM_W - FRAC_BITS;
  localparam int FX_W    = MX_W + 1;          // signed force

  localparam int IN_W    = 9 * FIELD_W;
  localparam int OUT_W   = 4 * FIELD_W;
  localparam int IDX_W   = 8;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_STIFFNESS = 8'd0;
  localparam logic [IDX_W-1:0] REG_DAMPING   = 8'd1;

  // Sideband carried through the square root
  typedef struct packed {
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    logic                     sx;
    logic                     sy;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    logic [FIELD_W-1:0]       rest;
  } sq_side_t;

  // Sideband carried through the divider
  typedef struct packed {
    logic                     sx;
    logic                     sy;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    logic [FIELD_W-1:0]       rest;
    logic [LEN_W-1:0]         len;
  } div_side_t;

  // Clamp a signed force to the 32-bit field range
  function automatic logic [FIELD_W-1:0] sat32(input logic signed [FX_W-1:0] v);
    logic signed [FX_W-1:0] hi;
    logic signed [FX_W-1:0] lo;
    hi = FX_W'(64'sd2147483647);
    lo = FX_W'(-64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[FIELD_W-1:0];
    end
  endfunction

endpackage

// ===== src/dsf_sqrt.sv =====
// ----------------------------------------------------------------------------
// dsf_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module dsf_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [dsf_pkg::RAD_W-1:0]    in_rad,
  input  dsf_pkg::sq_side_t            in_side,
  output logic                         out_vld,
  output logic [dsf_pkg::LEN_W-1:0]    out_root,
  output dsf_pkg::sq_side_t            out_side
);

  localparam int N = dsf_pkg::SQ_STAGES;
  localparam int RW = dsf_pkg::REM_W;
  localparam int LW = dsf_pkg::LEN_W;

  logic                        vld_q  [0:N-1];
  logic [RW-1:0]               rem_q  [0:N-1];
  logic [LW-1:0]               root_q [0:N-1];
  logic [dsf_pkg::RAD_W-1:0]   rad_q  [0:N-1];
  dsf_pkg::sq_side_t           side_q [0:N-1];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int P = N - 1 - j;
    logic                      vld_i;
    logic [RW-1:0]             rem_i;
    logic [LW-1:0]             root_i;
    logic [dsf_pkg::RAD_W-1:0] rad_i;
    dsf_pkg::sq_side_t         side_i;
    logic [RW+1:0]             rem_sh;
    logic [RW+1:0]             trial;
    logic [RW+1:0]             diff;
    logic                      fits;

    if (j == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_q[j-1];
      assign rem_i  = rem_q[j-1];
      assign root_i = root_q[j-1];
      assign rad_i  = rad_q[j-1];
      assign side_i = side_q[j-1];
    end

    // Bring down the next bit pair and try root*4+1
    always_comb begin
      rem_sh = {rem_i, rad_i[2*P+1], rad_i[2*P]};
      trial  = {1'b0, root_i, 2'b01};
      fits   = rem_sh >= trial;
      diff   = rem_sh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[j]  <= fits ? diff[RW-1:0] : rem_sh[RW-1:0];
        root_q[j] <= {root_i[LW-2:0], fits};
        rad_q[j]  <= rad_i;
        side_q[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[N-1];
  assign out_root = root_q[N-1];
  assign out_side = side_q[N-1];

endmodule

// ===== src/dsf_div.sv =====
// ----------------------------------------------------------------------------
// dsf_div
// Two-lane pipelined restoring divider for the unit direction components.
// ----------------------------------------------------------------------------
module dsf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [dsf_pkg::DIFF_W-1:0]   in_ax,
  input  logic [dsf_pkg::DIFF_W-1:0]   in_ay,
  input  dsf_pkg::div_side_t           in_side,
  output logic                         out_vld,
  output logic [dsf_pkg::Q_W-1:0]      out_qx,
  output logic [dsf_pkg::Q_W-1:0]      out_qy,
  output dsf_pkg::div_side_t           out_side
);

  localparam int N  = dsf_pkg::DIV_STAGES;
  localparam int NW = dsf_pkg::NUM_W;
  localparam int QW = dsf_pkg::Q_W;

  logic                vld_q  [0:N-1];
  logic [NW-1:0]       rx_q   [0:N-1];
  logic [NW-1:0]       ry_q   [0:N-1];
  logic [QW-1:0]       qx_q   [0:N-1];
  logic [QW-1:0]       qy_q   [0:N-1];
  dsf_pkg::div_side_t  side_q [0:N-1];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic                vld_i;
    logic [NW-1:0]       rx_i;
    logic [NW-1:0]       ry_i;
    logic [QW-1:0]       qx_i;
    logic [QW-1:0]       qy_i;
    dsf_pkg::div_side_t  side_i;
    logic [NW:0]         dsh;
    logic                fx;
    logic                fy;

    if (j == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rx_i   = {in_ax, dsf_pkg::FRAC_BITS'(0)};
      assign ry_i   = {in_ay, dsf_pkg::FRAC_BITS'(0)};
      assign qx_i   = '0;
      assign qy_i   = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_q[j-1];
      assign rx_i   = rx_q[j-1];
      assign ry_i   = ry_q[j-1];
      assign qx_i   = qx_q[j-1];
      assign qy_i   = qy_q[j-1];
      assign side_i = side_q[j-1];
    end

    // Compare the remainder against the divisor at this quotient weight
    always_comb begin
      dsh = (NW+1)'(side_i.len) << K;
      fx  = {1'b0, rx_i} >= dsh;
      fy  = {1'b0, ry_i} >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_q[j]   <= fx ? rx_i - dsh[NW-1:0] : rx_i;
        ry_q[j]   <= fy ? ry_i - dsh[NW-1:0] : ry_i;
        qx_q[j]   <= {qx_i[QW-2:0], fx};
        qy_q[j]   <= {qy_i[QW-2:0], fy};
        side_q[j] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[N-1];
  assign out_qx   = qx_q[N-1];
  assign out_qy   = qy_q[N-1];
  assign out_side = side_q[N-1];

endmodule

// ===== src/damped_spring_force_2d.sv =====
// ----------------------------------------------------------------------------
// damped_spring_force_2d
// Damped Hooke spring force between two points in the plane, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      one spring (positions, velocities,
//                                          rest length)
// m_axis    out  m_axis_tvalid/tready      forces on both endpoints
// cfg       in   cfg_valid/cfg_ready       register index and write data
//
// One spring enters per cycle while the output is not stalled. The pipeline has
// 3 difference and square stages, 33 square root stages (one root bit each), 17
// divider stages (one quotient bit each) and 8 stages of products, sums and clamping.
// Reset (rst, synchronous) clears all valid bits and both constants.
// A beat waiting at the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module damped_spring_force_2d (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x,
  // first_vel_y, second_vel_x, second_vel_y, rest_length
  input  logic [dsf_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // first_force_x, first_force_y, second_force_x, second_force_y
  output logic [dsf_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dsf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dsf_pkg::FIELD_W-1:0] cfg_data
);

  localparam int FW = dsf_pkg::FIELD_W;
  localparam int DW = dsf_pkg::DIFF_W;
  localparam int F  = dsf_pkg::FRAC_BITS;
  localparam int QW = dsf_pkg::Q_W;

  logic          adv;
  logic [FW-1:0] stiffness;
  logic [FW-1:0] damping;

  // Whole pipeline moves unless the output beat is stalled
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= '0;
      damping   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsf_pkg::REG_STIFFNESS: stiffness <= cfg_data;
        dsf_pkg::REG_DAMPING:   damping   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: differences and magnitudes
  logic signed [DW-1:0] dx, dy;
  logic                 vld_a;
  dsf_pkg::sq_side_t    side_a;

  always_comb begin
    dx = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
       - $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
    dy = $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
       - $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a.ax   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      side_a.ay   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      side_a.sx   <= dx[DW-1];
      side_a.sy   <= dy[DW-1];
      side_a.dvx  <= $signed({s_axis_tdata[159], s_axis_tdata[159:128]})
                   - $signed({s_axis_tdata[223], s_axis_tdata[223:192]});
      side_a.dvy  <= $signed({s_axis_tdata[191], s_axis_tdata[191:160]})
                   - $signed({s_axis_tdata[255], s_axis_tdata[255:224]});
      side_a.rest <= s_axis_tdata[287:256];
    end
  end

  // Stage B: squares
  logic                         vld_b;
  logic [dsf_pkg::RAD_W-1:0]    sqx, sqy;
  dsf_pkg::sq_side_t            side_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (adv) begin
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx    <= side_a.ax * side_a.ax;
      sqy    <= side_a.ay * side_a.ay;
      side_b <= side_a;
    end
  end

  // Stage C: squared length
  logic                         vld_c;
  logic [dsf_pkg::RAD_W-1:0]    rad;
  dsf_pkg::sq_side_t            side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (adv) begin
      vld_c <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad    <= sqx + sqy;
      side_c <= side_b;
    end
  end

  // Length by square root
  logic                         vld_r;
  logic [dsf_pkg::LEN_W-1:0]    len_r;
  dsf_pkg::sq_side_t            side_r;
  dsf_pkg::div_side_t           dside_in;

  dsf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (vld_c),
    .in_rad   (rad),
    .in_side  (side_c),
    .out_vld  (vld_r),
    .out_root (len_r),
    .out_side (side_r)
  );

  always_comb begin
    dside_in.sx   = side_r.sx;
    dside_in.sy   = side_r.sy;
    dside_in.dvx  = side_r.dvx;
    dside_in.dvy  = side_r.dvy;
    dside_in.rest = side_r.rest;
    dside_in.len  = len_r;
  end

  // Unit direction by division
  logic                 vld_q;
  logic [QW-1:0]        qx_q, qy_q;
  dsf_pkg::div_side_t   side_q;

  dsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (vld_r),
    .in_ax    (side_r.ax),
    .in_ay    (side_r.ay),
    .in_side  (dside_in),
    .out_vld  (vld_q),
    .out_qx   (qx_q),
    .out_qy   (qy_q),
    .out_side (side_q)
  );

  // Valid bits of the back end, stages D to K
  logic [7:0] vld_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_t <= '0;
    end else if (adv) begin
      vld_t <= {vld_t[6:0], vld_q};
    end
  end

  // Direction and flags travel alongside
  logic [QW-1:0] qx_d, qy_d, qx_e, qy_e, qx_f, qy_f, qx_g, qy_g, qx_h, qy_h, qx_i, qy_i;
  logic          sx_d, sy_d, sx_e, sy_e, sx_f, sy_f, sx_g, sy_g, sx_h, sy_h, sx_i, sy_i;
  logic          zr_d, zr_e, zr_f, zr_g, zr_h, zr_i, zr_j;

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_d <= qx_q; qy_d <= qy_q; sx_d <= side_q.sx; sy_d <= side_q.sy;
      zr_d <= side_q.len == '0;
      qx_e <= qx_d; qy_e <= qy_d; sx_e <= sx_d; sy_e <= sy_d; zr_e <= zr_d;
      qx_f <= qx_e; qy_f <= qy_e; sx_f <= sx_e; sy_f <= sy_e; zr_f <= zr_e;
      qx_g <= qx_f; qy_g <= qy_f; sx_g <= sx_f; sy_g <= sy_f; zr_g <= zr_f;
      qx_h <= qx_g; qy_h <= qy_g; sx_h <= sx_g; sy_h <= sy_g; zr_h <= zr_g;
      qx_i <= qx_h; qy_i <= qy_h; sx_i <= sx_h; sy_i <= sy_h; zr_i <= zr_h;
      zr_j <= zr_i;
    end
  end

  // Stage D: unit times relative velocity, stretch
  logic signed [QW:0]             ux, uy;
  logic signed [dsf_pkg::P_W-1:0] px, py;
  logic signed [DW:0]             stretch;

  always_comb begin
    ux = side_q.sx ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
    uy = side_q.sy ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px      <= dsf_pkg::P_W'(ux * side_q.dvx);
      py      <= dsf_pkg::P_W'(uy * side_q.dvy);
      stretch <= $signed({1'b0, side_q.len}) - $signed({2'b00, side_q.rest});
    end
  end

  // Stage E: raw dot product, stretch magnitude
  logic signed [dsf_pkg::DR_W-1:0] dotraw;
  logic [dsf_pkg::STR_W-1:0]       stm_e, stm_f;
  logic                            stn_e, stn_f;

  always_ff @(posedge clk) begin
    if (adv) begin
      dotraw <= dsf_pkg::DR_W'(px) + dsf_pkg::DR_W'(py);
      stm_e  <= stretch[DW] ? dsf_pkg::STR_W'(-stretch) : dsf_pkg::STR_W'(stretch);
      stn_e  <= stretch[DW];
    end
  end

  // Stage F: dot product back to the fixed-point scale, truncated toward zero
  logic [dsf_pkg::DR_W-1:0]  dabs;
  logic [dsf_pkg::DOT_W-1:0] dotm;
  logic                      dotn;

  assign dabs = dotraw[dsf_pkg::DR_W-1] ? dsf_pkg::DR_W'(-dotraw) : dsf_pkg::DR_W'(dotraw);

  always_ff @(posedge clk) begin
    if (adv) begin
      dotm  <= dabs[F +: dsf_pkg::DOT_W];
      dotn  <= dotraw[dsf_pkg::DR_W-1];
      stm_f <= stm_e;
      stn_f <= stn_e;
    end
  end

  // Stage G: spring and damper terms
  logic [FW+dsf_pkg::STR_W-1:0] kprod;
  logic [FW+dsf_pkg::DOT_W-1:0] dprod;
  logic [dsf_pkg::KS_W-1:0]     ks;
  logic [dsf_pkg::DS_W-1:0]     ds;
  logic                         ksn, dsn;

  always_comb begin
    kprod = stiffness * stm_f;
    dprod = damping * dotm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ks  <= kprod[F +: dsf_pkg::KS_W];
      ds  <= dprod[F +: dsf_pkg::DS_W];
      ksn <= stn_f;
      dsn <= dotn;
    end
  end

  // Stage H: signed scalar
  logic signed [dsf_pkg::S_W-1:0] kss, dss, scal;

  always_comb begin
    kss = $signed(dsf_pkg::S_W'(ks));
    dss = $signed(dsf_pkg::S_W'(ds));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scal <= (ksn ? -kss : kss) + (dsn ? -dss : dss);
    end
  end

  // Stage I: scalar magnitude and sign
  logic [dsf_pkg::SM_W-1:0] sm;
  logic                     sn;

  always_ff @(posedge clk) begin
    if (adv) begin
      sm <= scal[dsf_pkg::S_W-1] ? dsf_pkg::SM_W'(-scal) : dsf_pkg::SM_W'(scal);
      sn <= scal[dsf_pkg::S_W-1];
    end
  end

  // Stage J: force magnitudes
  logic [QW+dsf_pkg::SM_W-1:0] mxp, myp;
  logic [dsf_pkg::MX_W-1:0]    mx, my;
  logic                        nx, ny;

  always_comb begin
    mxp = qx_i * sm;
    myp = qy_i * sm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx <= mxp[F +: dsf_pkg::MX_W];
      my <= myp[F +: dsf_pkg::MX_W];
      nx <= sx_i ^ sn;
      ny <= sy_i ^ sn;
    end
  end

  // Stage K: sign, clamp, zero for coincident endpoints
  logic signed [dsf_pkg::FX_W-1:0] fxm, fym, fx, fy;

  always_comb begin
    fxm = $signed({1'b0, mx});
    fym = $signed({1'b0, my});
    fx  = nx ? fxm : -fxm;
    fy  = ny ? fym : -fym;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zr_j) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata <= {dsf_pkg::sat32(-fy), dsf_pkg::sat32(-fx),
                         dsf_pkg::sat32(fy), dsf_pkg::sat32(fx)};
      end
    end
  end

  assign m_axis_tvalid = vld_t[7];

endmodule

// ===== src/dsf_chk.sv =====
// ----------------------------------------------------------------------------
// dsf_chk
// Port-level checker of the spring force block, bound to the top level.
// ----------------------------------------------------------------------------
`include "damped_spring_force_2d_macros.svh"

module dsf_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dsf_pkg::OUT_W-1:0]   m_axis_tdata,
  input logic                        cfg_ready
);

  logic [31:0] f1x, f2x, f1y, f2y;
  logic        pair_x, pair_y;

  // Second force is the clamped negation of the first
  always_comb begin
    f1x = m_axis_tdata[31:0];
    f1y = m_axis_tdata[63:32];
    f2x = m_axis_tdata[95:64];
    f2y = m_axis_tdata[127:96];
    pair_x = (f2x == 32'(-f1x)) || (f1x == 32'h8000_0000 && f2x == 32'h7FFF_FFFF)
          || (f1x == 32'h7FFF_FFFF && f2x == 32'h8000_0000);
    pair_y = (f2y == 32'(-f1y)) || (f1y == 32'h8000_0000 && f2y == 32'h7FFF_FFFF)
          || (f1y == 32'h7FFF_FFFF && f2y == 32'h8000_0000);
  end

  `DSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `DSF_ASSERT_NOW(a_in_open, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
  `DSF_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready, "configuration write refused")
  `DSF_ASSERT_NOW(a_force_pair, m_axis_tvalid, pair_x && pair_y, "forces on endpoints not opposite")

endmodule

bind damped_spring_force_2d dsf_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the damped spring force pipeline: springs are
// streamed in under several idle and stall patterns, forces are predicted
// per beat and compared field by field against the output stream.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    logic [31:0]        rest;
  } spring_t;

  typedef struct {
    logic [31:0] f1x, f1y, f2x, f2y;
  } force_t;

  // Index outside the register map, writes to it are dropped
  localparam logic [dsf_pkg::IDX_W-1:0] REG_UNUSED = 8'd7;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [dsf_pkg::IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [dsf_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [dsf_pkg::IDX_W-1:0] cfg_index;
  logic [dsf_pkg::FIELD_W-1:0] cfg_data;

  damped_spring_force_2d u_dut (.*);

  // Predictor copy of the constants
  logic [31:0] k_stiff;
  logic [31:0] k_damp;

  spring_t spring_q[$];
  force_t  force_q[$];
  int      sent_cnt;
  int      recv_cnt;
  int      err_cnt;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      recv_hold;
  int      idle_cnt;
  int      hold_cnt;
  int      zero_len_cnt;
  int      sat_cnt;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Floor square root of a value below 2^66
  function automatic logic [32:0] root_floor(input logic [65:0] v);
    logic [32:0] r;
    logic [65:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = 66'(r | (33'd1 << b));
      if (t * t <= v) begin
        r = r | (33'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -128'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Product of magnitudes shifted down, truncated toward zero, sign applied
  function automatic logic signed [127:0] fix_mul(input logic signed [127:0] a,
                                                  input logic signed [127:0] b);
    logic [127:0] m;
    logic signed [127:0] r;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> dsf_pkg::FRAC_BITS;
    r = m;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic force_t spring_force(input spring_t s);
    force_t f;
    logic signed [127:0] dx, dy, dvx, dvy, ux, uy, dotraw, dot, str, sc, fx, fy;
    logic [65:0] rad;
    logic [32:0] len;
    dx  = s.p1x - s.p2x;
    dy  = s.p1y - s.p2y;
    dvx = s.v1x - s.v2x;
    dvy = s.v1y - s.v2y;
    rad = 66'(dx * dx + dy * dy);
    len = root_floor(rad);
    if (len == 0) begin
      f.f1x = '0; f.f1y = '0; f.f2x = '0; f.f2y = '0;
      return f;
    end
    ux = ((dx < 0 ? -dx : dx) <<< dsf_pkg::FRAC_BITS) / len;
    uy = ((dy < 0 ? -dy : dy) <<< dsf_pkg::FRAC_BITS) / len;
    if (dx < 0) ux = -ux;
    if (dy < 0) uy = -uy;
    dotraw = ux * dvx + uy * dvy;
    dot = (dotraw < 0 ? -dotraw : dotraw) >> dsf_pkg::FRAC_BITS;
    if (dotraw < 0) dot = -dot;
    str = $signed({95'd0, len}) - $signed({96'd0, s.rest});
    sc  = fix_mul($signed({96'd0, k_stiff}), str)
        + fix_mul($signed({96'd0, k_damp}), dot);
    fx = -fix_mul(ux, sc);
    fy = -fix_mul(uy, sc);
    f.f1x = clamp32(fx);
    f.f1y = clamp32(fy);
    f.f2x = clamp32(-fx);
    f.f2y = clamp32(-fy);
    return f;
  endfunction

  // Drive springs from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        force_q.push_back(spring_force(spring_q.pop_front()));
        sent_cnt <= sent_cnt + 1;
      end
      if (spring_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {spring_q[0].rest, spring_q[0].v2y, spring_q[0].v2x,
                          spring_q[0].v1y, spring_q[0].v1x, spring_q[0].p2y,
                          spring_q[0].p2x, spring_q[0].p1y, spring_q[0].p1x};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Check force beats and set the next ready
  always @(posedge clk) begin
    force_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        recv_cnt <= recv_cnt + 1;
        if (force_q.size() == 0) begin
          $error("unexpected force beat %h", m_axis_tdata);
          err_cnt = err_cnt + 1;
        end else begin
          want = force_q.pop_front();
          if (m_axis_tdata[31:0] !== want.f1x) begin
            $error("first_force_x exp %h got %h", want.f1x, m_axis_tdata[31:0]);
            err_cnt = err_cnt + 1;
          end
          if (m_axis_tdata[63:32] !== want.f1y) begin
            $error("first_force_y exp %h got %h", want.f1y, m_axis_tdata[63:32]);
            err_cnt = err_cnt + 1;
          end
          if (m_axis_tdata[95:64] !== want.f2x) begin
            $error("second_force_x exp %h got %h", want.f2x, m_axis_tdata[95:64]);
            err_cnt = err_cnt + 1;
          end
          if (m_axis_tdata[127:96] !== want.f2y) begin
            $error("second_force_y exp %h got %h", want.f2y, m_axis_tdata[127:96]);
            err_cnt = err_cnt + 1;
          end
          if (want.f1x == 32'h7FFF_FFFF || want.f1x == 32'h8000_0000) begin
            sat_cnt <= sat_cnt + 1;
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles of the long receiver hold
  always @(posedge clk) begin
    if (!recv_hold) begin
      hold_cnt <= 0;
    end else begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Watchdog: cycles with no beat accepted on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [dsf_pkg::IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dsf_pkg::REG_STIFFNESS) k_stiff = val;
    else if (idx == dsf_pkg::REG_DAMPING) k_damp = val;
  endtask

  // Wait for every expected force, then let the pipeline drain
  task automatic drain();
    while (spring_q.size() > 0 || s_axis_tvalid || force_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic add_spring(input logic [31:0] p1x, p1y, p2x, p2y,
                            v1x, v1y, v2x, v2y, rest);
    spring_t s;
    s.p1x = p1x; s.p1y = p1y; s.p2x = p2x; s.p2y = p2y;
    s.v1x = v1x; s.v1y = v1y; s.v2x = v2x; s.v2y = v2y; s.rest = rest;
    if (p1x == p2x && p1y == p2y) zero_len_cnt++;
    spring_q.push_back(s);
  endtask

  task automatic add_random(input int n);
    logic [31:0] bx, by;
    for (int i = 0; i < n; i++) begin
      bx = rnd_word();
      by = rnd_word();
      if ($urandom_range(19) == 0) begin
        // coincident endpoints
        add_spring(bx, by, bx, by, rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   $urandom());
      end else if ($urandom_range(3) == 0) begin
        add_spring(bx, by, rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   rnd_word(), rnd_word(), $urandom());
      end else begin
        // nearby endpoints with a rest length near the real one
        add_spring(bx, by, bx + $urandom_range(32'h0008_0000) - 32'h0004_0000,
                   by + $urandom_range(32'h0008_0000) - 32'h0004_0000,
                   rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   $urandom_range(32'h0006_0000));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    k_stiff = '0;
    k_damp = '0;
    sent_cnt = 0;
    recv_cnt = 0;
    err_cnt = 0;
    zero_len_cnt = 0;
    sat_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset constants give zero force, then extremes
    add_spring(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
    write_reg(dsf_pkg::REG_STIFFNESS, 32'h0001_0000);
    write_reg(dsf_pkg::REG_DAMPING, 32'h0000_8000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    add_spring(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h10);
    add_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    add_spring(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'hFFFF_FFFF);
    add_spring(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 32'h0005_0000);
    add_spring(32'hFFFD_0000, 32'h0004_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 0);
    add_spring(1, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    add_spring(0, 32'hFFFF_FFFF, 0, 0, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1);
    drain();
    write_reg(dsf_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(dsf_pkg::REG_DAMPING, 32'hFFFF_FFFF);
    add_spring(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0,
               32'h8000_0000, 0, 0);
    add_spring(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 32'hFFFF_FFFF);
    add_spring(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_spring(5, 5, 5, 5, 32'h7FFF_FFFF, 1, 2, 3, 7);
    drain();

    // Random phases under varied constants and traffic
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(dsf_pkg::REG_STIFFNESS, 0);
          write_reg(dsf_pkg::REG_DAMPING, $urandom());
        end
        1: begin
          write_reg(dsf_pkg::REG_STIFFNESS, $urandom_range(32'h0004_0000));
          write_reg(dsf_pkg::REG_DAMPING, 0);
        end
        default: begin
          write_reg(dsf_pkg::REG_STIFFNESS, $urandom());
          write_reg(dsf_pkg::REG_DAMPING, $urandom_range(32'h0002_0000));
        end
      endcase
      send_idle_pct  = (ph == 1) ? 53 : (ph >= 3 ? 16 : 0);
      recv_stall_pct = (ph == 2) ? 53 : (ph >= 3 ? 16 : 0);
      add_random(150);
      if (ph == 0) begin
        // long receiver hold so the pipeline fills and backs up the input
        recv_hold = 1'b1;
        wait (hold_cnt >= 300);
        recv_hold = 1'b0;
      end
      drain();
    end

    $display("Sent %0d springs, checked %0d force beats, %0d coincident, %0d clamped.",
             sent_cnt, recv_cnt, zero_len_cnt, sat_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
